FILE: rtl/sarld_pkg.sv
// ----------------------------------------------------------------------------
// sarld_pkg
// Shared types and constants of the stepper axis ramp/limit driver.
// ----------------------------------------------------------------------------
package sarld_pkg;

    localparam int unsigned PHASE_W = 4;
    localparam int unsigned POS_W   = 15;
    localparam int unsigned ACCEL_W = 4;
    localparam int unsigned IDLE_W  = 16;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Item opcodes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Move commands; the fourth code is treated as a stop.
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DOWN = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXPOS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE   = 2'd2;

    // Reset values.
    localparam logic [ACCEL_W-1:0] ACCEL_RESET  = 4'd3;
    localparam logic [POS_W-1:0]   MAXPOS_RESET = 15'd28900;
    localparam logic [IDLE_W-1:0]  IDLE_RESET   = 16'd455;
    localparam logic [PHASE_W-1:0] PHASE_RESET  = 4'b0001;

    typedef struct packed {
        logic              opcode;
        logic [CMD_W-1:0]  move_cmd;
        logic              axis_enabled;
        logic              calibrate;
        logic [POS_W-1:0]  load_value;
    } t_item;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_bits;
        logic [POS_W-1:0]   position;
        logic               stepped;
        logic               coils_released;
        logic               save_request;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

FILE: rtl/stepper_axis_ramp_limit_driver_core.sv
// ----------------------------------------------------------------------------
// stepper_axis_ramp_limit_driver_core
// One stepper axis in unipolar wave drive with start-up ramp, soft limits
// and idle release of the coils.
// ----------------------------------------------------------------------------
// Flow: a transaction accepted into the input register is applied to the
// axis when it moves on, and its result enters the result register as it is
// applied, staying on offer there until the consumer takes it.
// Throughput: one transaction per cycle while the consumer takes results;
// the axis state is updated in the same cycle the item leaves the input register.
// Reset: synchronous, active low; clears both pipeline stages and restores
// the configuration and axis state to their power-on values.
// ----------------------------------------------------------------------------
module stepper_axis_ramp_limit_driver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [1:0]  i_move_cmd,
    input  logic        i_axis_enabled,
    input  logic        i_calibrate,
    input  logic [14:0] i_load_value,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_phase_bits,
    output logic [14:0] o_position,
    output logic        o_stepped,
    output logic        o_coils_released,
    output logic        o_save_request
);

    sarld_pkg::t_item   in_item;
    sarld_pkg::t_item   stage_item;
    sarld_pkg::t_result core_result;
    sarld_pkg::t_result out_result;
    sarld_pkg::t_cfg_wr cfg_wr;
    logic               stage_valid;
    logic               advance;
    logic               fire;

    assign in_item.opcode       = i_opcode;
    assign in_item.move_cmd     = i_move_cmd;
    assign in_item.axis_enabled = i_axis_enabled;
    assign in_item.calibrate    = i_calibrate;
    assign in_item.load_value   = i_load_value;

    assign cfg_wr.we    = i_cfg_we;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    // The input register holds the next item to be applied to the axis. The
    // pipeline moves as a whole: an item is applied to the state exactly when
    // its result is loaded into the result register, so the state never runs
    // ahead of the delivered results.
    sarld_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    assign fire = stage_valid && advance;

    // Ramp, limits, phase rotation and idle release are all resolved in one
    // pass of combinational logic against the registered axis state.
    sarld_axis_core u_axis_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .i_fire   (fire),
        .i_item   (stage_item),
        .o_result (core_result)
    );

    // The result register separates the consumer from the input side, so a
    // new transaction is taken while an earlier result is still on offer if the
    // input register is empty or the consumer takes that result in the same cycle.
    sarld_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (stage_valid),
        .i_result  (core_result),
        .i_ready   (i_out_ready),
        .o_advance (advance),
        .o_valid   (o_out_valid),
        .o_result  (out_result)
    );

    assign o_phase_bits     = out_result.phase_bits;
    assign o_position       = out_result.position;
    assign o_stepped        = out_result.stepped;
    assign o_coils_released = out_result.coils_released;
    assign o_save_request   = out_result.save_request;

    // A driven coil pattern is always a single phase.
    a_phase_onehot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_phase_bits))
        else $error("phase pattern drives more than one coil");

    // Released coils carry no drive.
    a_release_dark : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_coils_released) |-> (o_phase_bits == 4'd0))
        else $error("coils driven while released");

    // A save is only requested at the moment of release.
    a_save_on_release : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_save_request) |-> (o_coils_released && !o_stepped))
        else $error("save request without coil release");

    // A step always energizes the coils.
    a_step_drives : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stepped) |-> (!o_coils_released && o_phase_bits != 4'd0))
        else $error("step taken with coils released");

endmodule

FILE: rtl/sarld_in_stage.sv
// ----------------------------------------------------------------------------
// sarld_in_stage
// Input register of the driver: captures one transaction per cycle while its item can move on.
// ----------------------------------------------------------------------------
module sarld_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sarld_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output sarld_pkg::t_item o_item
);

    logic             r_valid;
    sarld_pkg::t_item r_item;

    // The stage frees up whenever its item moves on to the result register.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/sarld_axis_core.sv
// ----------------------------------------------------------------------------
// sarld_axis_core
// Axis state, configuration registers and the per-item next-state logic.
// ----------------------------------------------------------------------------
module sarld_axis_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sarld_pkg::t_cfg_wr i_cfg,
    input  logic               i_fire,
    input  sarld_pkg::t_item   i_item,
    output sarld_pkg::t_result o_result
);

    logic [sarld_pkg::ACCEL_W-1:0] r_accel;
    logic [sarld_pkg::POS_W-1:0]   r_max_pos;
    logic [sarld_pkg::IDLE_W-1:0]  r_idle_ticks;

    logic [sarld_pkg::PHASE_W-1:0] r_phase,      n_phase;
    logic [sarld_pkg::POS_W-1:0]   r_pos,        n_pos;
    logic [sarld_pkg::ACCEL_W-1:0] r_ramp_start, n_ramp_start;
    logic [sarld_pkg::ACCEL_W-1:0] r_ramp_wait,  n_ramp_wait;
    logic [sarld_pkg::IDLE_W-1:0]  r_idle_cnt,   n_idle_cnt;
    logic                          r_armed,      n_armed;
    logic                          r_released,   n_released;
    logic [sarld_pkg::POS_W-1:0]   r_saved,      n_saved;

    logic                          stepped;
    logic                          consumed;
    logic                          save;
    logic [sarld_pkg::IDLE_W-1:0]  idle_inc;
    logic [sarld_pkg::ACCEL_W-1:0] ramp_dec;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel      <= sarld_pkg::ACCEL_RESET;
            r_max_pos    <= sarld_pkg::MAXPOS_RESET;
            r_idle_ticks <= sarld_pkg::IDLE_RESET;
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                sarld_pkg::CFG_ACCEL:  r_accel      <= i_cfg.data[sarld_pkg::ACCEL_W-1:0];
                sarld_pkg::CFG_MAXPOS: r_max_pos    <= i_cfg.data[sarld_pkg::POS_W-1:0];
                sarld_pkg::CFG_IDLE:   r_idle_ticks <= i_cfg.data[sarld_pkg::IDLE_W-1:0];
                default: ;
            endcase
        end
    end

    assign idle_inc = r_idle_cnt + 16'd1;
    assign ramp_dec = r_ramp_start - 4'd1;

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_ramp_start = r_ramp_start;
        n_ramp_wait  = r_ramp_wait;
        n_idle_cnt   = r_idle_cnt;
        n_armed      = r_armed;
        n_released   = r_released;
        n_saved      = r_saved;
        stepped      = 1'b0;
        consumed     = 1'b0;
        save         = 1'b0;

        if (i_fire) begin
            if (i_item.opcode == sarld_pkg::OP_LOAD) begin
                n_pos   = i_item.load_value;
                n_saved = i_item.load_value;
            end else begin
                if (i_item.move_cmd != sarld_pkg::CMD_UP &&
                    i_item.move_cmd != sarld_pkg::CMD_DOWN) begin
                    // Stop restarts the ramp from the configured count.
                    n_ramp_start = r_accel;
                    n_ramp_wait  = '0;
                end else if (i_item.axis_enabled) begin
                    if (r_ramp_wait != '0) begin
                        n_ramp_wait = r_ramp_wait - 4'd1;
                        consumed    = 1'b1;
                    end else begin
                        if (i_item.move_cmd == sarld_pkg::CMD_UP) begin
                            if (i_item.calibrate || r_pos < r_max_pos) begin
                                n_pos   = i_item.calibrate ? 15'd1 : r_pos + 15'd1;
                                n_phase = {r_phase[2:0], r_phase[3]};
                                stepped = 1'b1;
                            end
                        end else begin
                            if (i_item.calibrate || r_pos != '0) begin
                                n_pos   = i_item.calibrate ? 15'd0 : r_pos - 15'd1;
                                n_phase = {r_phase[0], r_phase[3:1]};
                                stepped = 1'b1;
                            end
                        end
                        if (r_ramp_start != '0) begin
                            n_ramp_start = ramp_dec;
                            n_ramp_wait  = ramp_dec;
                        end
                        consumed = stepped;
                    end
                end

                if (stepped) begin
                    n_released = 1'b0;
                end

                if (consumed) begin
                    n_armed    = 1'b1;
                    n_idle_cnt = '0;
                end else if (r_armed) begin
                    n_idle_cnt = idle_inc;
                    if (idle_inc >= r_idle_ticks) begin
                        n_armed    = 1'b0;
                        n_idle_cnt = '0;
                        n_released = 1'b1;
                        save       = (n_pos != r_saved);
                        n_saved    = n_pos;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= sarld_pkg::PHASE_RESET;
            r_pos        <= '0;
            r_ramp_start <= sarld_pkg::ACCEL_RESET;
            r_ramp_wait  <= '0;
            r_idle_cnt   <= '0;
            r_armed      <= 1'b0;
            r_released   <= 1'b1;
            r_saved      <= '0;
        end else begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_ramp_start <= n_ramp_start;
            r_ramp_wait  <= n_ramp_wait;
            r_idle_cnt   <= n_idle_cnt;
            r_armed      <= n_armed;
            r_released   <= n_released;
            r_saved      <= n_saved;
        end
    end

    assign o_result.phase_bits     = n_released ? '0 : n_phase;
    assign o_result.position       = n_pos;
    assign o_result.stepped        = stepped;
    assign o_result.coils_released = n_released;
    assign o_result.save_request   = save;

endmodule

FILE: rtl/sarld_out_stage.sv
// ----------------------------------------------------------------------------
// sarld_out_stage
// Result register: holds a finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module sarld_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sarld_pkg::t_result i_result,
    input  logic               i_ready,
    output logic               o_advance,
    output logic               o_valid,
    output sarld_pkg::t_result o_result
);

    logic               r_valid;
    sarld_pkg::t_result r_result;

    // The register can load when it is empty or its content leaves now.
    assign o_advance = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: tb/sarld_tb_pkg.sv
// ----------------------------------------------------------------------------
// sarld_tb_pkg
// Scoreboard for the stepper axis driver: keeps its own copy of the axis
// state and registers, predicts one result per transaction and checks the
// results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package sarld_tb_pkg;

    import sarld_pkg::*;

    class t_axis_scoreboard;

        // Register copies.
        logic [ACCEL_W-1:0]    cfg_accel;
        logic [POS_W-1:0]      cfg_max_pos;
        logic [IDLE_W-1:0]     cfg_idle;

        // Axis state.
        logic [PHASE_W-1:0]    coil_phase;
        logic [POS_W-1:0]      axis_pos;
        logic [ACCEL_W-1:0]    ramp_reload;
        logic [ACCEL_W-1:0]    ramp_hold;
        logic [IDLE_W-1:0]     idle_run;
        logic                  armed;
        logic                  released;
        logic [POS_W-1:0]      saved_pos;

        t_result               due_results[$];

        int unsigned           mismatches;
        int unsigned           n_items;
        int unsigned           n_loads;
        int unsigned           n_steps;
        int unsigned           n_blocked;
        int unsigned           n_releases;
        int unsigned           n_saves;
        int unsigned           n_checked;
        int unsigned           n_reg_writes;

        function new();
            mismatches   = 0;
            n_items      = 0;
            n_loads      = 0;
            n_steps      = 0;
            n_blocked    = 0;
            n_releases   = 0;
            n_saves      = 0;
            n_checked    = 0;
            n_reg_writes = 0;
            power_on();
        endfunction

        function void power_on();
            cfg_accel   = ACCEL_RESET;
            cfg_max_pos = MAXPOS_RESET;
            cfg_idle    = IDLE_RESET;
            coil_phase  = PHASE_RESET;
            axis_pos    = '0;
            ramp_reload = ACCEL_RESET;
            ramp_hold   = '0;
            idle_run    = '0;
            armed       = 1'b0;
            released    = 1'b1;
            saved_pos   = '0;
            due_results.delete();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            n_reg_writes++;
            case (idx)
                CFG_ACCEL:  cfg_accel   = val[ACCEL_W-1:0];
                CFG_MAXPOS: cfg_max_pos = val[POS_W-1:0];
                CFG_IDLE:   cfg_idle    = val[IDLE_W-1:0];
                default: ;
            endcase
        endfunction

        // Advances the axis by one accepted transaction and queues its result.
        function void note_accepted(t_item it);
            t_result r;
            logic    stepped;
            logic    consumed;
            logic    save;
            logic    moving;
            stepped  = 1'b0;
            consumed = 1'b0;
            save     = 1'b0;
            n_items++;
            if (it.opcode == OP_LOAD) begin
                n_loads++;
                axis_pos  = it.load_value;
                saved_pos = it.load_value;
            end else begin
                moving = (it.move_cmd == CMD_UP) || (it.move_cmd == CMD_DOWN);
                if (!moving) begin
                    ramp_reload = cfg_accel;
                    ramp_hold   = '0;
                end else if (it.axis_enabled) begin
                    if (ramp_hold != '0) begin
                        ramp_hold = ramp_hold - ACCEL_W'(1);
                        consumed  = 1'b1;
                    end else begin
                        if (it.move_cmd == CMD_UP) begin
                            if (it.calibrate || axis_pos < cfg_max_pos) begin
                                axis_pos   = it.calibrate ? POS_W'(1) : axis_pos + POS_W'(1);
                                coil_phase = {coil_phase[2:0], coil_phase[3]};
                                stepped    = 1'b1;
                            end
                        end else begin
                            if (it.calibrate || axis_pos != '0) begin
                                axis_pos   = it.calibrate ? '0 : axis_pos - POS_W'(1);
                                coil_phase = {coil_phase[0], coil_phase[3:1]};
                                stepped    = 1'b1;
                            end
                        end
                        if (!stepped)
                            n_blocked++;
                        if (ramp_reload != '0) begin
                            ramp_reload = ramp_reload - ACCEL_W'(1);
                            ramp_hold   = ramp_reload;
                        end
                        consumed = stepped;
                    end
                end
                if (stepped) begin
                    released = 1'b0;
                    n_steps++;
                end
                if (consumed) begin
                    armed    = 1'b1;
                    idle_run = '0;
                end else if (armed) begin
                    idle_run = idle_run + IDLE_W'(1);
                    if (idle_run >= cfg_idle) begin
                        armed     = 1'b0;
                        idle_run  = '0;
                        released  = 1'b1;
                        save      = (axis_pos != saved_pos);
                        saved_pos = axis_pos;
                        n_releases++;
                        if (save)
                            n_saves++;
                    end
                end
            end
            r.phase_bits     = released ? '0 : coil_phase;
            r.position       = axis_pos;
            r.stepped        = stepped;
            r.coils_released = released;
            r.save_request   = save;
            due_results.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= 30)
                $display("MISMATCH at result %0d: %s got %0h expected %0h",
                         n_checked, what, got, want);
        endtask

        task check_result(t_result got);
            t_result want;
            n_checked++;
            if (due_results.size() == 0) begin
                report("result with no transaction waiting", 32'(got), 0);
                return;
            end
            want = due_results.pop_front();
            if (got.phase_bits !== want.phase_bits)
                report("phase_bits", 32'(got.phase_bits), 32'(want.phase_bits));
            if (got.position !== want.position)
                report("position", 32'(got.position), 32'(want.position));
            if (got.stepped !== want.stepped)
                report("stepped", 32'(got.stepped), 32'(want.stepped));
            if (got.coils_released !== want.coils_released)
                report("coils_released", 32'(got.coils_released),
                       32'(want.coils_released));
            if (got.save_request !== want.save_request)
                report("save_request", 32'(got.save_request), 32'(want.save_request));
        endtask

        function int unsigned pending();
            return due_results.size();
        endfunction

    endclass

endpackage

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stepper axis ramp/limit driver. Directed
// transactions cover the ramp, both soft limits, calibration, loads and the
// idle release; randomized phases then sweep the registers through their
// extremes with bursty input and a stalling result consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    import sarld_pkg::*;
    import sarld_tb_pkg::*;

    // The fourth move code behaves as a stop.
    localparam logic [CMD_W-1:0] CMD_HOLD = 2'd3;

    // The limit leaves a wide margin over the worst correct run.
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned PHASES       = 8;

    // Receiver behaviors, switched at random intervals.
    typedef enum int unsigned {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_STALLS
    } t_rx_mode;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  opcode     = OP_TICK;
    logic [CMD_W-1:0]      move_cmd   = CMD_STOP;
    logic                  axis_en    = 1'b0;
    logic                  calib      = 1'b0;
    logic [POS_W-1:0]      load_value = '0;
    logic                  out_ready  = 1'b0;

    logic                  in_ready;
    logic                  out_valid;
    logic [PHASE_W-1:0]    phase_bits;
    logic [POS_W-1:0]      position;
    logic                  stepped;
    logic                  coils_released;
    logic                  save_request;

    t_axis_scoreboard      sb;

    int unsigned           burst_left   = 0;
    t_rx_mode              rx_mode      = RX_OPEN;
    int unsigned           rx_mode_left = 0;
    int unsigned           rx_stall     = 0;
    int unsigned           rx_tick      = 0;
    int unsigned           cycles       = 0;

    stepper_axis_ramp_limit_driver_core i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_opcode         (opcode),
        .i_move_cmd       (move_cmd),
        .i_axis_enabled   (axis_en),
        .i_calibrate      (calib),
        .i_load_value     (load_value),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_phase_bits     (phase_bits),
        .o_position       (position),
        .o_stepped        (stepped),
        .o_coils_released (coils_released),
        .o_save_request   (save_request)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Transaction builders. Fields that a transaction does not use still get
    // random values so that every input bit toggles.
    // ------------------------------------------------------------------------
    function automatic t_item tick_item(logic [CMD_W-1:0] cmd, logic en, logic cal);
        t_item it;
        it.opcode       = OP_TICK;
        it.move_cmd     = cmd;
        it.axis_enabled = en;
        it.calibrate    = cal;
        it.load_value   = POS_W'($urandom);
        return it;
    endfunction

    function automatic t_item load_item(logic [POS_W-1:0] val);
        t_item it;
        it.opcode       = OP_LOAD;
        it.move_cmd     = CMD_W'($urandom);
        it.axis_enabled = 1'($urandom);
        it.calibrate    = 1'($urandom);
        it.load_value   = val;
        return it;
    endfunction

    function automatic t_item noise_item();
        logic [$bits(t_item)-1:0] raw;
        raw = $bits(t_item)'($urandom);
        return t_item'(raw);
    endfunction

    // Load values cluster around zero and around the upper soft limit (on
    // both sides of it), so that the limit cases are reached often.
    function automatic logic [POS_W-1:0] pick_load();
        logic [POS_W-1:0] top;
        top = sb.cfg_max_pos;
        case ($urandom_range(0, 3))
            0: return POS_W'($urandom_range(0, 3));
            1: return top - POS_W'($urandom_range(0, (top < 3) ? top : 3));
            2: return top + POS_W'($urandom_range(1, 3));
            default: return POS_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input driver. Valid is raised with the payload and held until the
    // transaction is accepted. The sender works in bursts and idles at the
    // start of each new burst. Now and then a burst is long, which gives
    // stretches without any sender idling.
    // ------------------------------------------------------------------------
    task send_item(t_item it);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        in_valid   <= 1'b1;
        opcode     <= it.opcode;
        move_cmd   <= it.move_cmd;
        axis_en    <= it.axis_enabled;
        calib      <= it.calibrate;
        load_value <= it.load_value;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_accepted(it);
    endtask

    // Every transaction yields exactly one result, so once nothing is
    // outstanding the block is idle and registers may be written.
    task wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Writes all three registers on consecutive edges.
    task write_regs(logic [ACCEL_W-1:0] accel, logic [POS_W-1:0] max_pos,
                    logic [IDLE_W-1:0] idle);
        logic [CFG_DATA_W-1:0] vals[3];
        logic [CFG_IDX_W-1:0]  idxs[3];
        vals[0] = CFG_DATA_W'(accel);
        vals[1] = CFG_DATA_W'(max_pos);
        vals[2] = CFG_DATA_W'(idle);
        idxs[0] = CFG_ACCEL;
        idxs[1] = CFG_MAXPOS;
        idxs[2] = CFG_IDLE;
        cfg_we <= 1'b1;
        for (int k = 0; k < 3; k++) begin
            cfg_index <= idxs[k];
            cfg_data  <= vals[k];
            @(posedge clk);
            sb.write_reg(idxs[k], vals[k]);
        end
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // One randomized phase. Most of the traffic is runs of enabled moves in
    // one direction, which is what gets the axis through the ramp and out to
    // the limits. Runs of stop codes let the idle counter expire and release
    // the coils. Loads, fully random transactions and disabled moves are
    // mixed in. Disabled moves do not step the axis and do not count
    // toward the quota.
    // ------------------------------------------------------------------------
    task run_phase(int unsigned quota);
        int unsigned      done;
        int unsigned      sel;
        int unsigned      len;
        logic [CMD_W-1:0] dir;
        logic             cal;
        done = 0;
        while (done < quota) begin
            sel = $urandom_range(0, 99);
            dir = $urandom_range(0, 1) ? CMD_UP : CMD_DOWN;
            if (sel < 55) begin
                cal = ($urandom_range(0, 9) == 0);
                len = $urandom_range(1, 40);
                repeat (len) begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(noise_item());
                    else
                        send_item(tick_item(dir, 1'b1, cal));
                    done++;
                end
            end else if (sel < 72) begin
                len = $urandom_range(1, 24);
                repeat (len) begin
                    send_item(tick_item($urandom_range(0, 1) ? CMD_STOP : CMD_HOLD,
                                        1'($urandom), 1'($urandom)));
                    done++;
                end
            end else if (sel < 82) begin
                send_item(load_item(pick_load()));
                done++;
            end else if (sel < 92) begin
                send_item(noise_item());
                done++;
            end else begin
                repeat ($urandom_range(1, 8))
                    send_item(tick_item(dir, 1'b0, 1'($urandom)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side. A result is checked at the edge where valid and ready are
    // both high, using the values seen at that edge. Ready follows a pattern
    // that changes at random: always ready, coin flips, a periodic hole, or
    // bursts of stalls.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(t_result'({phase_bits, position, stepped,
                                       coils_released, save_request}));
        rx_tick++;
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(40, 300);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RX_OPEN:     out_ready <= 1'b1;
            RX_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
            RX_PERIODIC: out_ready <= (rx_tick % 4 != 0);
            default: begin
                if (rx_stall != 0) begin
                    rx_stall--;
                    out_ready <= 1'b0;
                end else begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        rx_stall = $urandom_range(1, 8);
                end
            end
        endcase
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [ACCEL_W-1:0] accel;
        logic [POS_W-1:0]   max_pos;
        logic [IDLE_W-1:0]  idle;

        sb = new();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with the power-on registers (ramp of three, upper
        // limit 28900). A decrease at position zero is blocked but still
        // advances the ramp; the following increases show the waits between
        // the first steps.
        send_item(tick_item(CMD_DOWN, 1'b1, 1'b0));
        repeat (5) send_item(tick_item(CMD_UP, 1'b1, 1'b0));
        // Calibration sets the position to one on an increase and to zero on a decrease, and ignores the limits.
        send_item(tick_item(CMD_UP, 1'b1, 1'b1));
        send_item(tick_item(CMD_DOWN, 1'b1, 1'b1));
        // The fourth code acts as a stop; a disabled move does not step the axis.
        send_item(tick_item(CMD_HOLD, 1'b1, 1'b0));
        send_item(tick_item(CMD_UP, 1'b0, 1'b0));
        // A position above the limit blocks increases but not decreases; here the decreases fall in the ramp waits.
        send_item(load_item('1));
        send_item(tick_item(CMD_UP, 1'b1, 1'b0));
        repeat (2) send_item(tick_item(CMD_DOWN, 1'b1, 1'b0));
        // Exactly at the limit, and then at zero.
        send_item(load_item(MAXPOS_RESET));
        send_item(tick_item(CMD_UP, 1'b1, 1'b0));
        send_item(load_item('0));
        send_item(tick_item(CMD_STOP, 1'b0, 1'b1));
        send_item(load_item(15'h2AAA));
        send_item(load_item(15'h5555));

        // Short idle timeout and no ramp: after a step, two stop ticks
        // release the coils with a save request. A step up and back down
        // leaves the position at its saved value, so that release comes
        // without a save request.
        wait_drained();
        write_regs('0, MAXPOS_RESET, IDLE_W'(2));
        send_item(tick_item(CMD_UP, 1'b1, 1'b0));
        repeat (2) send_item(tick_item(CMD_STOP, 1'b1, 1'b0));
        send_item(tick_item(CMD_UP, 1'b1, 1'b0));
        send_item(tick_item(CMD_DOWN, 1'b1, 1'b0));
        repeat (2) send_item(tick_item(CMD_STOP, 1'b1, 1'b0));

        // Randomized phases. The first two pin the register extremes, the third a
        // full ramp with a small limit; the rest pick settings at random, often with
        // a small limit and mostly a short idle timeout so limits and releases are frequent.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    accel   = '0;
                    max_pos = POS_W'(1);
                    idle    = IDLE_W'(1);
                end
                1: begin
                    accel   = '1;
                    max_pos = '1;
                    idle    = '1;
                end
                2: begin
                    accel   = '1;
                    max_pos = POS_W'($urandom_range(1, 16));
                    idle    = IDLE_W'(1);
                end
                default: begin
                    accel   = ACCEL_W'($urandom_range(0, 15));
                    max_pos = $urandom_range(0, 1) ? POS_W'($urandom_range(1, 64))
                                                   : POS_W'($urandom_range(1, 32767));
                    idle    = ($urandom_range(0, 9) < 7) ? IDLE_W'($urandom_range(1, 12))
                                                        : IDLE_W'($urandom_range(1, 65535));
                end
            endcase
            wait_drained();
            write_regs(accel, max_pos, idle);
            run_phase(RANDOM_ITEMS / PHASES);
        end

        // Drain, then keep clocking the pipeline before the last check so that a stray
        // extra result would still be caught.
        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
            sb.report("results never delivered", sb.pending(), 0);

        $display("Run covered %0d transactions (%0d position loads) and %0d register writes.",
                 sb.n_items, sb.n_loads, sb.n_reg_writes);
        $display("Axis took %0d steps, was held at a limit %0d times, released %0d times"
                 , sb.n_steps, sb.n_blocked, sb.n_releases);
        $display("with %0d save requests; %0d mismatches.", sb.n_saves, sb.mismatches);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
